// ===== design/apct_pkg.sv =====
// apct_pkg: types, sizes and event codes shared by the contact tracker modules
// no dependencies
package apct_pkg;

	localparam int ID_W       = 6;
	localparam int ID_BITS    = 6;
	localparam int PAIR_BITS  = 2 * ID_BITS;
	localparam int PAIR_DEPTH = 1 << PAIR_BITS;
	localparam int POS_W      = 24;
	localparam int SIZE_W     = 16;
	localparam int DIFF_W     = POS_W + 1;
	localparam int SUM_W      = SIZE_W + 1;
	localparam int LIM_W      = SUM_W + 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} contact_event_t;

	typedef struct packed {
		logic        [ID_W-1:0]   first_id;
		logic        [ID_W-1:0]   second_id;
		logic signed [POS_W-1:0]  first_cx;
		logic signed [POS_W-1:0]  first_cy;
		logic signed [POS_W-1:0]  second_cx;
		logic signed [POS_W-1:0]  second_cy;
		logic signed [SIZE_W-1:0] first_w;
		logic signed [SIZE_W-1:0] first_h;
		logic signed [SIZE_W-1:0] second_w;
		logic signed [SIZE_W-1:0] second_h;
	} pair_t;

	typedef struct packed {
		contact_event_t contact_event;
		logic           overlapping;
	} result_t;

	typedef struct packed {
		logic [PAIR_BITS-1:0] idx;
		logic                 ov;
	} job_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RESOLVE
	} back_state_t;

	typedef struct packed {
		logic                 pop;
		logic                 we;
		logic [PAIR_BITS-1:0] wa;
		logic                 wd;
		logic                 emit;
		logic                 clr_inc;
	} back_ctl_t;

endpackage

// ===== design/aabb_pair_contact_tracker.sv =====
// aabb_pair_contact_tracker: top level, box overlap front, job queue, contact back
// depends on apct_pkg, apct_front, apct_queue, apct_back
//
//   channel   handshake        payload          beat
//   input     push / full      pair   (pair_t)  one ordered collider pair
//   result    pop / empty      result (result_t) one event per pair
//
// the front takes a beat every cycle while full is low into a two stage overlap
// pipeline and a four entry queue; the back handles each pair on the contact memory
// in IDLE (registered read) and then RESOLVE (write), so it takes no new pair until
// the last one is written; a result passes both overlap stages, the queue, the read
// and the result register; after reset the back clears the 4096 entry contact memory
// with full held high; the front keeps filling the queue while a result waits on pop
module aabb_pair_contact_tracker import apct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  pair_t   pair,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic q_push, q_full, q_pop, q_empty, clearing;
	job_t q_wr_item, q_rd_item;

	apct_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pair   (pair),
		.hold   (clearing),
		.q_push (q_push),
		.q_item (q_wr_item),
		.q_full (q_full)
	);

	apct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_item (q_wr_item),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_item (q_rd_item),
		.q_empty (q_empty)
	);

	apct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (q_rd_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ===== design/apct_front.sv =====
// apct_front: accepts pairs and tests box overlap in two pipeline stages
// depends on apct_pkg
module apct_front import apct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  pair_t pair,
	input  logic  hold,
	output logic  q_push,
	output job_t  q_item,
	input  logic  q_full
);

	logic                     valid_s1, valid_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [SUM_W-1:0]  sw_s1, sh_s1;
	logic [PAIR_BITS-1:0]     idx_s1;
	job_t                     job_s2;
	logic                     ready_s1, ready_s2, accept;

	logic [DIFF_W-1:0]        adx, ady;
	logic signed [LIM_W-1:0]  limx, limy, wx, wy;
	logic [LIM_W-1:0]         alx, aly;
	logic                     ov;

	assign ready_s2 = !valid_s2 || !q_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full     = !ready_s1 || hold;
	assign accept   = push && !full;
	assign q_push   = valid_s2 && !q_full;
	assign q_item   = job_s2;

	always_comb begin
		adx  = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		ady  = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		wx   = LIM_W'(sw_s1);
		wy   = LIM_W'(sh_s1);
		// times 50 as 32 + 16 + 2
		limx = (wx <<< 5) + (wx <<< 4) + (wx <<< 1);
		limy = (wy <<< 5) + (wy <<< 4) + (wy <<< 1);
		alx  = limx[LIM_W-1] ? LIM_W'(-limx) : LIM_W'(limx);
		aly  = limy[LIM_W-1] ? LIM_W'(-limy) : LIM_W'(limy);
		ov   = (adx < DIFF_W'(alx)) && (ady < DIFF_W'(aly));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= accept;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_s1  <= {pair.first_cx[POS_W-1], pair.first_cx}
			        - {pair.second_cx[POS_W-1], pair.second_cx};
			dy_s1  <= {pair.first_cy[POS_W-1], pair.first_cy}
			        - {pair.second_cy[POS_W-1], pair.second_cy};
			sw_s1  <= {pair.first_w[SIZE_W-1], pair.first_w}
			        + {pair.second_w[SIZE_W-1], pair.second_w};
			sh_s1  <= {pair.first_h[SIZE_W-1], pair.first_h}
			        + {pair.second_h[SIZE_W-1], pair.second_h};
			idx_s1 <= {pair.first_id[ID_BITS-1:0], pair.second_id[ID_BITS-1:0]};
		end
		if (ready_s2 && valid_s1) begin
			job_s2.idx <= idx_s1;
			job_s2.ov  <= ov;
		end
	end

endmodule

// ===== design/apct_queue.sv =====
// apct_queue: short job queue between the overlap front and the contact back
// depends on apct_pkg
module apct_queue import apct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_item,
	output logic q_full,
	input  logic rd,
	output job_t rd_item,
	output logic q_empty
);

	job_t              slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_full  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_empty = cnt_q == '0;
	assign rd_item = slots[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slots[wp_q] <= wr_item;
	end

endmodule

// ===== design/apct_back.sv =====
// apct_back: contact bit memory, clearing pass, event decision and result register
// depends on apct_pkg
module apct_back import apct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  job_t    q_item,
	output logic    q_pop,
	output logic    clearing,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	back_state_t          state_q, state_d;
	back_ctl_t            ctl;
	logic [PAIR_BITS-1:0] clr_q;
	job_t                 job_q;
	logic                 prev_q;
	logic                 out_valid_q;
	result_t              result_q;
	logic                 contact_mem [PAIR_DEPTH];
	logic                 out_take;

	assign out_take = out_valid_q && pop;
	assign empty    = !out_valid_q;
	assign result   = result_q;
	assign q_pop    = ctl.pop;
	assign clearing = state_q == BK_CLEAR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR:   if (clr_q == '1) state_d = BK_IDLE;
			BK_IDLE:    if (ctl.pop) state_d = BK_RESOLVE;
			BK_RESOLVE: state_d = BK_IDLE;
			default:    state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			BK_CLEAR: begin
				ctl.we      = 1'b1;
				ctl.wa      = clr_q;
				ctl.wd      = 1'b0;
				ctl.clr_inc = 1'b1;
			end
			BK_IDLE: begin
				ctl.pop = !q_empty && (!out_valid_q || pop);
			end
			BK_RESOLVE: begin
				ctl.we   = 1'b1;
				ctl.wa   = job_q.idx;
				ctl.wd   = job_q.ov;
				ctl.emit = 1'b1;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.clr_inc) clr_q <= clr_q + 1'b1;
			if (ctl.emit) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) contact_mem[ctl.wa] <= ctl.wd;
		if (ctl.pop) begin
			prev_q <= contact_mem[q_item.idx];
			job_q  <= q_item;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q.overlapping <= job_q.ov;
			case ({job_q.ov, prev_q})
				2'b10:   result_q.contact_event <= EV_ENTER;
				2'b11:   result_q.contact_event <= EV_STAY;
				2'b01:   result_q.contact_event <= EV_EXIT;
				default: result_q.contact_event <= EV_NONE;
			endcase
		end
	end

endmodule

// ===== tb/sv/apct_contact_monitor.sv =====
// apct_contact_monitor: watches both channels of the contact tracker, predicts each
// event from its own contact bit map and compares every result beat in order
// depends on apct_pkg
module apct_contact_monitor import apct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  pair_t   pair,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      awaiting,
	output int      seen_enter,
	output int      seen_stay,
	output int      seen_exit,
	output int      seen_none
);
	timeunit 1ns;
	timeprecision 1ps;

	logic    contact_map [PAIR_DEPTH];
	result_t expected_events [$];
	result_t want;

	function automatic logic axis_hit(logic signed [POS_W-1:0] ca, logic signed [POS_W-1:0] cb,
			logic signed [SIZE_W-1:0] sa, logic signed [SIZE_W-1:0] sb);
		longint d;
		longint lim;
		d = longint'(ca) - longint'(cb);
		lim = 50 * (longint'(sa) + longint'(sb));
		if (d < 0) d = -d;
		if (lim < 0) lim = -lim;
		return d < lim;
	endfunction

	function automatic result_t predict_contact(pair_t p);
		logic [PAIR_BITS-1:0] slot;
		logic                 hit;
		result_t              r;
		slot = {p.first_id[ID_BITS-1:0], p.second_id[ID_BITS-1:0]};
		hit = axis_hit(p.first_cx, p.second_cx, p.first_w, p.second_w) &&
			axis_hit(p.first_cy, p.second_cy, p.first_h, p.second_h);
		if (hit) begin
			if (contact_map[slot]) r.contact_event = EV_STAY;
			else r.contact_event = EV_ENTER;
		end else begin
			if (contact_map[slot]) r.contact_event = EV_EXIT;
			else r.contact_event = EV_NONE;
		end
		r.overlapping = hit;
		contact_map[slot] = hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (contact_map[i]) contact_map[i] = 1'b0;
			expected_events.delete();
			errors = 0;
			awaiting = 0;
			seen_enter = 0;
			seen_stay = 0;
			seen_exit = 0;
			seen_none = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					$display("%0t: result beat with nothing expected, got event %0d ovl %0b",
						$time, result.contact_event, result.overlapping);
					errors++;
				end else begin
					want = expected_events.pop_front();
					if (result.contact_event !== want.contact_event) begin
						$display("%0t: contact_event expected %0d, got %0d",
							$time, want.contact_event, result.contact_event);
						errors++;
					end
					if (result.overlapping !== want.overlapping) begin
						$display("%0t: overlapping expected %0b, got %0b",
							$time, want.overlapping, result.overlapping);
						errors++;
					end
					case (want.contact_event)
						EV_ENTER: seen_enter++;
						EV_STAY:  seen_stay++;
						EV_EXIT:  seen_exit++;
						default:  seen_none++;
					endcase
				end
			end
			if (push && !full)
				expected_events.push_back(predict_contact(pair));
			awaiting = expected_events.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// tb: drives collider pair beats into aabb_pair_contact_tracker under several idle and
// stall mixes and gives the verdict from the monitor's error count
// depends on apct_pkg, aabb_pair_contact_tracker, apct_contact_monitor
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import apct_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_ITEMS = 432;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	pair_t   pair = '0;
	logic    full;
	logic    empty;
	result_t result;

	int errors;
	int awaiting;
	int seen_enter;
	int seen_stay;
	int seen_exit;
	int seen_none;
	int send_idle = 0;
	int recv_stall = 0;
	int sent = 0;
	int quiet = 0;
	int idle_mix [4] = '{0, 71, 0, 34};
	int stall_mix [4] = '{0, 0, 71, 34};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aabb_pair_contact_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pair   (pair),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	apct_contact_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pair       (pair),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.errors     (errors),
		.awaiting   (awaiting),
		.seen_enter (seen_enter),
		.seen_stay  (seen_stay),
		.seen_exit  (seen_exit),
		.seen_none  (seen_none)
	);

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall);
	end

	function automatic pair_t pack_pair(int a, int b, int cx1, int cy1, int cx2, int cy2,
			int w1, int h1, int w2, int h2);
		pair_t p;
		p.first_id = ID_W'(a);
		p.second_id = ID_W'(b);
		p.first_cx = POS_W'(cx1);
		p.first_cy = POS_W'(cy1);
		p.second_cx = POS_W'(cx2);
		p.second_cy = POS_W'(cy2);
		p.first_w = SIZE_W'(w1);
		p.first_h = SIZE_W'(h1);
		p.second_w = SIZE_W'(w2);
		p.second_h = SIZE_W'(h2);
		return p;
	endfunction

	// mostly nearby boxes on a small set of revisited pairs, some raw noise
	function automatic pair_t random_pair();
		pair_t p;
		int    r;
		int    base_x;
		int    base_y;
		r = $urandom_range(99);
		if (r < 15) begin
			p = pack_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else begin
			base_x = $urandom;
			base_y = $urandom;
			p.first_id = ID_W'((r < 25) ? $urandom_range(63) : $urandom_range(7));
			p.second_id = ID_W'((r < 25) ? $urandom_range(63) : $urandom_range(7));
			p.first_cx = POS_W'(base_x);
			p.first_cy = POS_W'(base_y);
			p.second_cx = POS_W'(base_x + int'($urandom_range(160000)) - 80000);
			p.second_cy = POS_W'(base_y + int'($urandom_range(160000)) - 80000);
			p.first_w = SIZE_W'(int'($urandom_range(1200)) - 200);
			p.first_h = SIZE_W'(int'($urandom_range(1200)) - 200);
			p.second_w = SIZE_W'(int'($urandom_range(1200)) - 200);
			p.second_h = SIZE_W'(int'($urandom_range(1200)) - 200);
		end
		return p;
	endfunction

	task automatic send_pair(input pair_t p);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pair <= p;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		wait (awaiting == 0);
	endtask

	initial begin
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no beat for %0d cycles, %0d results outstanding", quiet, awaiting);
		$display("FAIL aabb_pair_contact_tracker");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// enter, stay, exit, none on one pair, strict boundary on both axes
		send_pair(pack_pair(0, 0, 0, 0, 0, 0, 256, 256, 256, 256));
		send_pair(pack_pair(0, 0, 0, 0, 0, 0, 256, 256, 256, 256));
		send_pair(pack_pair(0, 0, 0, 0, 25600, 0, 256, 256, 256, 256));
		send_pair(pack_pair(0, 0, 0, 0, 25600, 0, 256, 256, 256, 256));
		send_pair(pack_pair(0, 0, 0, 0, 25599, 0, 256, 256, 256, 256));
		send_pair(pack_pair(0, 0, 0, 0, 0, -25600, 256, 256, 256, 256));
		send_pair(pack_pair(0, 0, 0, 0, 0, -25599, 256, 256, 256, 256));
		// swapped ids keep separate contact bits
		send_pair(pack_pair(5, 9, 0, 0, 0, 0, 256, 256, 256, 256));
		send_pair(pack_pair(9, 5, 0, 0, 0, 0, 256, 256, 256, 256));
		send_pair(pack_pair(9, 5, 0, 0, 8000000, 0, 256, 256, 256, 256));
		send_pair(pack_pair(5, 9, 0, 0, 0, 0, 256, 256, 256, 256));
		// field extremes
		send_pair(pack_pair(63, 63, 8388607, 8388607, 8388607, 8388607,
			32767, 32767, 32767, 32767));
		send_pair(pack_pair(63, 0, -8388608, -8388608, 8388607, 8388607,
			32767, 32767, 32767, 32767));
		send_pair(pack_pair(0, 63, -8388608, -8388608, -8388608, -8388608,
			-32768, -32768, -32768, -32768));
		send_pair(pack_pair(0, 63, -8388608, -8388608, -8388608, -8388608,
			-32768, -32768, -32768, -32768));
		send_pair(pack_pair(63, 63, 8388607, 8388607, -8388608, -8388608,
			32767, 32767, 32767, 32767));
		// zero size sum never overlaps
		send_pair(pack_pair(1, 2, 0, 0, 0, 0, 100, 100, -100, -100));
		send_pair(pack_pair(1, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		// negative sizes use the magnitude of the sum
		send_pair(pack_pair(3, 3, 0, 0, 1, 1, -256, -256, 0, 0));
		send_pair(pack_pair(3, 3, 12800, 0, 0, 0, -256, 256, 0, 256));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_mix[ph];
			recv_stall = stall_mix[ph];
			repeat (PHASE_ITEMS) send_pair(random_pair());
			// hold the sender until every result is back
			drain();
		end

		repeat (16) @(posedge clk);
		$display("sent %0d collider pairs: directed edge cases, then four idle/stall mixes",
			sent);
		$display("events checked: %0d enter, %0d stay, %0d exit, %0d none",
			seen_enter, seen_stay, seen_exit, seen_none);
		if (errors == 0 && awaiting == 0)
			$display("PASS aabb_pair_contact_tracker");
		else
			$display("FAIL aabb_pair_contact_tracker");
		$finish;
	end

endmodule

// ===== files.f =====
design/apct_pkg.sv
design/apct_front.sv
design/apct_queue.sv
design/apct_back.sv
design/aabb_pair_contact_tracker.sv
tb/sv/apct_contact_monitor.sv
tb/sv/tb.sv
